// ===== hw/rtl/ipv4_fragment_header_generator_macros.svh =====
// ----------------------------------------------------------------------------
// IPv4 fragment header generator assertion macros
// Shared concurrent assertion helpers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_FRAGMENT_HEADER_GENERATOR_MACROS_SVH
`define IPV4_FRAGMENT_HEADER_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define IPFHG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ipfhg assertion failed");
// Checks that a condition in one cycle implies another in the next cycle.
`define IPFHG_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error("ipfhg assertion failed");
`else
`define IPFHG_ASSERT(lbl, prop)
`define IPFHG_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

// ===== hw/rtl/ipfhg_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 fragment header generator package
// Constants and the command type passed from the front end to the back end.
// ----------------------------------------------------------------------------
package ipfhg_pkg;

    localparam logic [15:0] IP_HDR_BYTES  = 16'd20;
    localparam logic [15:0] MIN_MTU       = 16'd1280;
    localparam logic [15:0] RESET_MTU     = 16'd1500;
    localparam logic [15:0] PAYLOAD_MASK  = 16'hFFF8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One packet request, already classified and tagged with its id and payload size.
    typedef struct packed {
        logic [7:0]  hdr_bytes;
        logic [15:0] usr_bytes;
        logic [15:0] payload;
        logic [15:0] id;
    } t_cmd;

endpackage

// ===== hw/rtl/ipfhg_pkt_if.sv =====
// ----------------------------------------------------------------------------
// Packet request channel
// Valid/ready channel carrying the header and user region sizes.
// ----------------------------------------------------------------------------
interface ipfhg_pkt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  header_bytes;
    logic [15:0] user_bytes;

    modport source (output valid, output header_bytes, output user_bytes, input ready);
    modport sink   (input valid, input header_bytes, input user_bytes, output ready);
endinterface

// ===== hw/rtl/ipfhg_frag_if.sv =====
// ----------------------------------------------------------------------------
// Fragment descriptor channel
// Valid/ready channel carrying one IPv4 fragment descriptor per transfer.
// ----------------------------------------------------------------------------
interface ipfhg_frag_if;
    logic        valid;
    logic        ready;
    logic        from_user_region;
    logic [15:0] data_start;
    logic [15:0] data_bytes;
    logic [15:0] total_length;
    logic [15:0] identification;
    logic [13:0] flags_offset;
    logic        last_fragment;

    modport source (
        output valid, output from_user_region, output data_start, output data_bytes,
        output total_length, output identification, output flags_offset,
        output last_fragment, input ready
    );
    modport sink (
        input valid, input from_user_region, input data_start, input data_bytes,
        input total_length, input identification, input flags_offset,
        input last_fragment, output ready
    );
endinterface

// ===== hw/rtl/ipfhg_front.sv =====
// ----------------------------------------------------------------------------
// IPv4 fragment header generator front end
// Holds the MTU register and packet id, accepts requests and queues commands.
// ----------------------------------------------------------------------------
module ipfhg_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    ipfhg_pkt_if.sink          i_pkt,
    input  logic               i_full,
    output logic               o_push,
    output ipfhg_pkg::t_cmd    o_cmd
);
    import ipfhg_pkg::*;

    logic [15:0] r_link_mtu;
    logic [15:0] r_packet_id;
    logic [15:0] mtu_eff;
    logic        accept;
    logic        empty_pkt;

    assign i_pkt.ready = !i_full;
    assign accept      = i_pkt.valid && i_pkt.ready;
    assign empty_pkt   = (i_pkt.header_bytes == 8'd0) && (i_pkt.user_bytes == 16'd0);
    assign mtu_eff     = (r_link_mtu < MIN_MTU) ? MIN_MTU : r_link_mtu;

    // An empty packet consumes an id but produces no fragments, so it is never queued.
    assign o_push          = accept && !empty_pkt;
    assign o_cmd.hdr_bytes = i_pkt.header_bytes;
    assign o_cmd.usr_bytes = i_pkt.user_bytes;
    assign o_cmd.payload   = (mtu_eff - IP_HDR_BYTES) & PAYLOAD_MASK;
    assign o_cmd.id        = r_packet_id + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_mtu  <= RESET_MTU;
            r_packet_id <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                r_link_mtu <= i_cfg_data;
            end
            if (accept) begin
                r_packet_id <= r_packet_id + 16'd1;
            end
        end
    end
endmodule

// ===== hw/rtl/ipfhg_queue.sv =====
// ----------------------------------------------------------------------------
// IPv4 fragment header generator command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "ipv4_fragment_header_generator_macros.svh"

module ipfhg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ipfhg_pkg::t_cmd    i_cmd,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output ipfhg_pkg::t_cmd    o_head
);
    import ipfhg_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
    endfunction

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

    `IPFHG_ASSERT(a_count_bound, r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    `IPFHG_ASSERT(a_no_underflow, i_pop |-> !o_empty)
    `IPFHG_ASSERT_NEXT(a_push_grows, i_push && !i_pop, r_count == $past(r_count) + QUEUE_CNT_W'(1))
endmodule

// ===== hw/rtl/ipfhg_back.sv =====
// ----------------------------------------------------------------------------
// IPv4 fragment header generator back end
// Cuts queued packets into fragments and drives the descriptor output register.
// ----------------------------------------------------------------------------
`include "ipv4_fragment_header_generator_macros.svh"

module ipfhg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  ipfhg_pkg::t_cmd    i_head,
    output logic               o_pop,
    ipfhg_frag_if.source       o_frag
);
    import ipfhg_pkg::*;

    logic        r_busy;
    logic        r_phase;
    logic [15:0] r_left;
    logic [15:0] r_pos;
    logic [15:0] r_cum;
    logic [15:0] r_usr;
    logic [15:0] r_payload;
    logic [15:0] r_id;

    logic        r_ov;
    logic        r_o_user;
    logic [15:0] r_o_start;
    logic [15:0] r_o_bytes;
    logic [15:0] r_o_total;
    logic [15:0] r_o_id;
    logic [13:0] r_o_flags;
    logic        r_o_last;

    logic [15:0] chunk;
    logic        region_done;
    logic        ends_packet;
    logic        last;
    logic        emit;

    assign chunk       = (r_left < r_payload) ? r_left : r_payload;
    assign region_done = (chunk == r_left);
    assign ends_packet = r_phase || (r_usr == 16'd0);
    assign last        = ends_packet && region_done;
    assign emit        = r_busy && (!r_ov || o_frag.ready);
    assign o_pop       = !r_busy && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (emit && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            // The queue never holds an empty packet, so one region is nonzero here.
            r_usr     <= i_head.usr_bytes;
            r_payload <= i_head.payload;
            r_id      <= i_head.id;
            r_pos     <= 16'd0;
            r_cum     <= 16'd0;
            if (i_head.hdr_bytes != 8'd0) begin
                r_phase <= 1'b0;
                r_left  <= {8'd0, i_head.hdr_bytes};
            end else begin
                r_phase <= 1'b1;
                r_left  <= i_head.usr_bytes;
            end
        end else if (emit) begin
            r_cum <= r_cum + chunk;
            if (region_done && !ends_packet) begin
                r_phase <= 1'b1;
                r_left  <= r_usr;
                r_pos   <= 16'd0;
            end else begin
                r_left <= r_left - chunk;
                r_pos  <= r_pos + chunk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_frag.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_user  <= r_phase;
            r_o_start <= r_pos;
            r_o_bytes <= chunk;
            r_o_total <= IP_HDR_BYTES + chunk;
            r_o_id    <= r_id;
            r_o_flags <= {!last, r_cum[15:3]};
            r_o_last  <= last;
        end
    end

    assign o_frag.valid            = r_ov;
    assign o_frag.from_user_region = r_o_user;
    assign o_frag.data_start       = r_o_start;
    assign o_frag.data_bytes       = r_o_bytes;
    assign o_frag.total_length     = r_o_total;
    assign o_frag.identification   = r_o_id;
    assign o_frag.flags_offset     = r_o_flags;
    assign o_frag.last_fragment    = r_o_last;

    `IPFHG_ASSERT(a_busy_has_bytes, r_busy |-> (r_left != 16'd0))
    `IPFHG_ASSERT(a_last_clears_mf, r_ov && r_o_last |-> !r_o_flags[13])
    `IPFHG_ASSERT_NEXT(a_last_ends_run, emit && last && !o_pop, !r_busy)
endmodule

// ===== hw/rtl/ipv4_fragment_header_generator.sv =====
// ----------------------------------------------------------------------------
// IPv4 fragment header generator
// Turns packet requests into a run of IPv4 fragment descriptors.
// ----------------------------------------------------------------------------
// Usage: a packet request (header region size, user region size) is sent on
// i_pkt; each transfer on o_frag is one fragment descriptor, and the final
// descriptor of a packet carries last_fragment. The MTU register is written
// with i_cfg_we / i_cfg_data while the block is idle; values below 1280 are
// treated as 1280.
// Flow: a request reaches the back end through a two-entry command queue.
// The back end loads a command into its run registers and then produces
// one descriptor per cycle while the receiver keeps o_frag.ready high; it
// takes the next command only once its run is done. A descriptor passes
// from the queue entry through the run registers to the output register.
// The fragment loop in the back end sets the throughput. A request with both
// sizes zero produces no descriptor but still advances the identification.
// The front end takes a request whenever the queue has room, so it keeps
// accepting while the back end works or the receiver stalls.
// When the receiver holds o_frag.ready low, the output register holds its
// descriptor and the fragment loop pauses until the transfer completes.
// Reset (synchronous, active low) empties the queue, drops any fragment run
// in progress, clears the identification counter and restores an MTU of 1500.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_generator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_data,
    ipfhg_pkt_if.sink    i_pkt,
    ipfhg_frag_if.source o_frag
);
    import ipfhg_pkg::*;

    // Command handoff between the front end and the queue.
    logic push;
    t_cmd push_cmd;

    // Queue status and head entry seen by the back end.
    logic q_full;
    logic q_empty;
    logic pop;
    t_cmd head_cmd;

    // The front end owns the MTU register and packet id; it classifies each
    // request, drops empty ones and queues the rest with their payload size.
    ipfhg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pkt      (i_pkt),
        .i_full     (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // The queue lets the front end keep accepting while a run is in progress.
    ipfhg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // The back end walks the header region and then the user region into the
    // registered output stage, one fragment per cycle unless o_frag stalls.
    ipfhg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_frag  (o_frag)
    );
endmodule

// ===== bench/ipv4_fragment_header_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 fragment header generator checker
// Watches the request, descriptor and MTU write ports, predicts the fragment
// run of every accepted request and compares each descriptor transfer.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    ipfhg_pkt_if        i_pkt,
    ipfhg_frag_if       i_frag,
    output int          o_error_count,
    output int          o_pending
);
    import ipfhg_pkg::*;

    typedef struct packed {
        logic        from_user_region;
        logic [15:0] data_start;
        logic [15:0] data_bytes;
        logic [15:0] total_length;
        logic [15:0] identification;
        logic [13:0] flags_offset;
        logic        last_fragment;
    } frag_desc_t;

    logic [15:0] link_mtu = RESET_MTU;
    logic [15:0] packet_id = '0;
    logic [15:0] packet_offset = '0;
    frag_desc_t  expected_frags[$];
    int          error_count = 0;
    int          pending_count = 0;

    assign o_error_count = error_count;
    assign o_pending     = pending_count;

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic string desc_text(input frag_desc_t d);
        return $sformatf("usr=%0d start=%0d bytes=%0d len=%0d id=%0d fo=%04h last=%0d",
                         d.from_user_region, d.data_start, d.data_bytes, d.total_length,
                         d.identification, d.flags_offset, d.last_fragment);
    endfunction

    // Cuts one region into payload-sized pieces and queues their descriptors.
    task automatic queue_region_frags(input logic [15:0] size, input logic user_region,
                                      input logic ends_packet, input logic [15:0] payload);
        logic [15:0] left;
        logic [15:0] pos;
        logic [15:0] chunk;
        frag_desc_t  d;
        left = size;
        pos  = '0;
        while (left != 16'd0) begin
            chunk              = (left < payload) ? left : payload;
            d.from_user_region = user_region;
            d.data_start       = pos;
            d.data_bytes       = chunk;
            d.total_length     = IP_HDR_BYTES + chunk;
            d.identification   = packet_id;
            d.last_fragment    = ends_packet && (chunk == left);
            d.flags_offset     = {~d.last_fragment, packet_offset[15:3]};
            expected_frags.push_back(d);
            pos           = pos + chunk;
            left          = left - chunk;
            packet_offset = packet_offset + chunk;
        end
    endtask

    task automatic predict_packet(input logic [7:0] hdr, input logic [15:0] usr);
        logic [15:0] mtu;
        logic [15:0] payload;
        mtu           = (link_mtu < MIN_MTU) ? MIN_MTU : link_mtu;
        payload       = (mtu - IP_HDR_BYTES) & PAYLOAD_MASK;
        packet_id     = packet_id + 16'd1;
        packet_offset = '0;
        queue_region_frags({8'd0, hdr}, 1'b0, usr == 16'd0, payload);
        if (usr != 16'd0) begin
            queue_region_frags(usr, 1'b1, 1'b1, payload);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        frag_desc_t got;
        frag_desc_t want;
        if (!i_rst_n) begin
            link_mtu  = RESET_MTU;
            packet_id = '0;
            expected_frags.delete();
        end else begin
            // Results are retired before a new request is predicted; a request
            // can never produce a descriptor in the cycle it is accepted.
            if (i_frag.valid && i_frag.ready) begin
                got = '{i_frag.from_user_region, i_frag.data_start, i_frag.data_bytes,
                        i_frag.total_length, i_frag.identification, i_frag.flags_offset,
                        i_frag.last_fragment};
                if (expected_frags.size() == 0) begin
                    report_error({"unexpected descriptor: ", desc_text(got)});
                end else begin
                    want = expected_frags.pop_front();
                    if (got !== want) begin
                        report_error({"descriptor mismatch: got ", desc_text(got),
                                      " expected ", desc_text(want)});
                    end
                end
            end
            if (i_pkt.valid && i_pkt.ready) begin
                predict_packet(i_pkt.header_bytes, i_pkt.user_bytes);
            end
            if (i_cfg_we) begin
                link_mtu = i_cfg_data;
            end
        end
        pending_count = expected_frags.size();
    end

endmodule

// ===== bench/tb_ipv4_fragment_header_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 fragment header generator testbench
// Drives packet requests and MTU settings into the generator with random
// backpressure on both channels; a checker beside the block predicts every
// fragment descriptor and compares it with the transfers it observes.
// ----------------------------------------------------------------------------
module tb_ipv4_fragment_header_generator;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    // When set, neither the request source nor the descriptor sink idles.
    logic        steady = 1'b0;

    int          error_count;
    int          pending;

    ipfhg_pkt_if  pkt_if ();
    ipfhg_frag_if frag_if ();

    ipv4_fragment_header_generator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pkt      (pkt_if),
        .o_frag     (frag_if)
    );

    ipv4_fragment_header_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_pkt         (pkt_if),
        .i_frag        (frag_if),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // 125 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block stalls or loses descriptors. The slowest
    // correct run, with every request at its longest fragment run under
    // stalls, is far shorter.
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Descriptor sink: ready is decided afresh at every falling edge, and is
    // dropped with a chance of about seven in a hundred unless the steady flag is
    // set. Ready has no hold rule, so every cycle is a fair place to stall.
    initial begin
        frag_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            frag_if.ready = steady || ($urandom_range(99) >= 7);
        end
    end

    // Presents one request and returns after the rising edge at which it
    // transfers. Idle cycles are only inserted before valid goes high, since
    // a presented request must stay put until it is taken. Each falling edge
    // assigns valid at most once.
    task automatic send_packet(input logic [7:0] hdr, input logic [15:0] usr);
        @(negedge i_clk);
        while (!steady && ($urandom_range(99) < 7)) begin
            pkt_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pkt_if.valid        = 1'b1;
        pkt_if.header_bytes = hdr;
        pkt_if.user_bytes   = usr;
        do @(posedge i_clk); while (!pkt_if.ready);
    endtask

    // Stops the request source and waits until every predicted descriptor
    // has arrived. Requests with both sizes zero produce nothing and are never
    // queued; the task then idles on further falling edges before it returns.
    task automatic drain;
        @(negedge i_clk);
        pkt_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // The MTU register is only written with the block idle.
    task automatic write_mtu(input logic [15:0] value);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // Random request. Most user regions are small so that packets split into
    // a handful of fragments; a few reach the full range and produce the
    // longest runs. Empty regions on either side are frequent.
    task automatic send_random_packet;
        logic [7:0]  hdr;
        logic [15:0] usr;
        int          pick;
        pick = $urandom_range(99);
        hdr  = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
        if (pick < 12) begin
            usr = 16'd0;
        end else if (pick < 75) begin
            usr = 16'($urandom_range(3000));
        end else if (pick < 90) begin
            usr = 16'($urandom_range(12000));
        end else begin
            usr = 16'($urandom_range(65279));
        end
        send_packet(hdr, usr);
    endtask

    initial begin : stimulus
        logic [15:0] phase_mtu [7];

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = '0;
        pkt_if.valid        = 1'b0;
        pkt_if.header_bytes = '0;
        pkt_if.user_bytes   = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset MTU of 1500 gives a 1480-byte fragment payload. The first
        // request is empty: it emits nothing but consumes identification 1.
        send_packet(8'd0, 16'd0);
        send_packet(8'd255, 16'd0);       // header only, last header fragment ends it
        send_packet(8'd0, 16'd1);         // user only
        send_packet(8'd1, 16'd0);
        send_packet(8'd1, 16'd1);         // header fragment sets more-fragments
        send_packet(8'd0, 16'd1480);      // exactly one payload
        send_packet(8'd0, 16'd1481);      // one byte spills into a second fragment
        send_packet(8'd255, 16'd1480);
        send_packet(8'd7, 16'd2960);      // offsets not a multiple of eight
        send_packet(8'd255, 16'd65279);   // header at its top value, largest user size
        send_packet(8'd0, 16'd65279);

        // An MTU below the minimum is raised to 1280, so the payload is 1256
        // and the largest request yields the longest possible run.
        write_mtu(16'd0);
        send_packet(8'd255, 16'd65279);
        send_packet(8'd0, 16'd1256);
        send_packet(8'd1, 16'd1255);
        send_packet(8'd170, 16'd21845);   // alternating bit patterns
        send_packet(8'd85, 16'd43690);

        // Largest MTU: every region fits in one fragment.
        write_mtu(16'd65535);
        send_packet(8'd255, 16'd65279);
        send_packet(8'd0, 16'd65279);
        send_packet(8'd128, 16'd0);

        // Back to the reset MTU for a few mixed requests.
        write_mtu(16'd1500);
        send_packet(8'd40, 16'd3000);
        send_packet(8'd0, 16'd100);
        send_packet(8'd8, 16'd0);

        // Random part in several MTU phases, extremes included. The second
        // phase runs without any idling on either side.
        phase_mtu[0] = 16'd1280;
        phase_mtu[1] = 16'd0;
        phase_mtu[2] = 16'd65535;
        phase_mtu[3] = 16'd1279;
        phase_mtu[4] = 16'($urandom_range(9000, 1280));
        phase_mtu[5] = 16'($urandom_range(65535, 1280));
        phase_mtu[6] = 16'($urandom_range(65535));
        for (int p = 0; p < 7; p++) begin
            write_mtu(phase_mtu[p]);
            steady = (p == 1);
            repeat (14) send_random_packet();
        end
        steady = 1'b0;

        // Let every outstanding descriptor arrive, then give the verdict. A
        // descriptor that never comes leaves the run to the hard stop.
        drain();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ipfhg_pkg.sv
hw/rtl/ipfhg_pkt_if.sv
hw/rtl/ipfhg_frag_if.sv
hw/rtl/ipfhg_front.sv
hw/rtl/ipfhg_queue.sv
hw/rtl/ipfhg_back.sv
hw/rtl/ipv4_fragment_header_generator.sv
bench/ipv4_fragment_header_checker.sv
bench/tb_ipv4_fragment_header_generator.sv
